### rtl/aws_pkg.sv
// Shared constants, codes and types for the acoustic wave stencil pipeline.
`timescale 1ns / 1ps

package aws_pkg;

   // Fixed field widths.
   localparam int COEF_W     = 32;
   localparam int FRAC_BITS  = 30;
   localparam int GRID_W     = 13;
   localparam int POS_W      = 12;
   localparam int VEL_W      = 14;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef logic [COEF_W-1:0] coef_type;

   // Configuration register indexes.
   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_RATIO_DEPTH   = 2'd0;
   localparam reg_index_type REG_RATIO_LATERAL = 2'd1;
   localparam reg_index_type REG_GRID_DEPTH    = 2'd2;
   localparam reg_index_type REG_GRID_WIDTH    = 2'd3;

   // Which coefficient scales a difference term.
   typedef logic [1:0] coef_sel_type;
   localparam coef_sel_type COEF_LINEAR      = 2'd0;
   localparam coef_sel_type COEF_HALF_SQUARE = 2'd1;
   localparam coef_sel_type COEF_SQUARE      = 2'd2;

   // Magnitude width used by the scaling unit; at least one bit above the fraction.
   function automatic int mag_width(input int diff_w);
      return (diff_w > FRAC_BITS) ? diff_w : FRAC_BITS + 1;
   endfunction

endpackage

### rtl/aws_scale.sv
// Three-stage signed difference times Q2.30 coefficient, rounded back to the sample format.
`timescale 1ns / 1ps

module aws_scale import aws_pkg::*; #(
   parameter int DIFF_W = 34,
   parameter int TERM_W = 38
) (
   input  logic                     clock,
   input  logic signed [DIFF_W-1:0] diff,
   input  coef_type                 coef,
   output logic signed [TERM_W-1:0] term
);

   localparam int MAG_W     = mag_width(DIFF_W);
   localparam int HI_W      = MAG_W - FRAC_BITS;
   localparam int LO_PROD_W = FRAC_BITS + COEF_W;
   localparam int HI_PROD_W = HI_W + COEF_W;
   localparam int R_W       = TERM_W - 1;
   localparam logic [LO_PROD_W:0] ROUND_HALF = (LO_PROD_W+1)'(1) << (FRAC_BITS - 1);

   // Stage A: sign and magnitude.
   logic signed [MAG_W:0]  diff_ext;
   logic signed [MAG_W:0]  abs_val;
   logic [MAG_W-1:0]       mag_in, mag_ff;
   logic                   neg_in, neg_a_ff;
   coef_type               coef_a_ff;

   // Stage B: split products.
   logic [LO_PROD_W-1:0]   lo_prod_in, lo_prod_ff;
   logic [HI_PROD_W-1:0]   hi_prod_in, hi_prod_ff;
   logic                   neg_b_ff;

   // Stage C: rounded and signed term.
   logic [LO_PROD_W:0]     lo_round;
   logic [R_W-1:0]         r_sum;
   logic signed [TERM_W-1:0] r_ext;
   logic signed [TERM_W-1:0] term_in, term_ff;

   assign diff_ext = (MAG_W+1)'(diff);
   assign neg_in   = diff_ext[MAG_W];
   assign abs_val  = neg_in ? -diff_ext : diff_ext;
   assign mag_in   = abs_val[MAG_W-1:0];

   assign lo_prod_in = LO_PROD_W'(mag_ff[FRAC_BITS-1:0]) * LO_PROD_W'(coef_a_ff);
   assign hi_prod_in = HI_PROD_W'(mag_ff[MAG_W-1:FRAC_BITS]) * HI_PROD_W'(coef_a_ff);

   // Rounding the low part alone is exact since the high part is a whole multiple.
   assign lo_round = {1'b0, lo_prod_ff} + ROUND_HALF;
   assign r_sum    = R_W'(hi_prod_ff) + R_W'(lo_round[LO_PROD_W:FRAC_BITS]);
   assign r_ext    = signed'({1'b0, r_sum});
   assign term_in  = neg_b_ff ? -r_ext : r_ext;

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      neg_a_ff   <= neg_in;
      coef_a_ff  <= coef;
      lo_prod_ff <= lo_prod_in;
      hi_prod_ff <= hi_prod_in;
      neg_b_ff   <= neg_a_ff;
      term_ff    <= term_in;
   end

   assign term = term_ff;

endmodule

### rtl/acoustic_wave_stencil_step.sv
// One grid cell of a 2D acoustic wave time step with absorbing edges, fully pipelined.
// Each accepted transaction yields one result strobe from the end of the valid pipeline.
// Throughput: one transaction per clock; busy never rises and results cannot be held off.
// The depth is set by the multiplier chain: Courant product, its square, and the split
// scaling multiply, each followed by a register.
// Synchronous reset clears the valid pipeline and returns the configuration registers
// to their reset values.
`timescale 1ns / 1ps

module acoustic_wave_stencil_step import aws_pkg::*; #(
   parameter int MAX_GRID    = 4096,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          start,
   output logic                          busy,
   input  logic [POS_W-1:0]              req_lateral_pos,
   input  logic [POS_W-1:0]              req_depth_pos,
   input  logic [VEL_W-1:0]              req_velocity,
   input  logic signed [SAMPLE_BITS-1:0] req_cur_center,
   input  logic signed [SAMPLE_BITS-1:0] req_cur_up,
   input  logic signed [SAMPLE_BITS-1:0] req_cur_down,
   input  logic signed [SAMPLE_BITS-1:0] req_cur_left,
   input  logic signed [SAMPLE_BITS-1:0] req_cur_right,
   input  logic signed [SAMPLE_BITS-1:0] req_prev_center,
   input  logic signed [SAMPLE_BITS-1:0] req_prev_up,
   input  logic signed [SAMPLE_BITS-1:0] req_prev_left,
   input  logic signed [SAMPLE_BITS-1:0] req_prev_right,

   output logic                          rsp_valid,
   output logic signed [SAMPLE_BITS-1:0] rsp_next_sample,
   output logic                          rsp_saturated,

   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_W-1:0]         paddr,
   input  logic [CSR_DATA_W-1:0]         pwdata,
   output logic [CSR_DATA_W-1:0]         prdata,
   output logic                          pready
);

   localparam int NZ_W    = ($clog2(MAX_GRID + 1) > GRID_W) ? $clog2(MAX_GRID + 1) : GRID_W;
   localparam int CMP_W   = NZ_W + 2;
   localparam int DIFF_W  = SAMPLE_BITS + 2;
   localparam int TERM_W  = (mag_width(DIFF_W) - FRAC_BITS) + COEF_W + 2;
   localparam int SUM_W   = ((TERM_W > DIFF_W) ? TERM_W : DIFF_W) + 2;
   localparam int PROD_W  = VEL_W + COEF_W;
   localparam int SQ_W    = 2 * COEF_W;
   localparam int LAT     = 8;

   localparam logic signed [CMP_W-1:0] ONE_S = CMP_W'(1);
   localparam logic signed [CMP_W-1:0] TWO_S = CMP_W'(2);
   localparam logic [PROD_W:0] PROD_RND     = (PROD_W+1)'(2);
   localparam logic [SQ_W:0]   SQ_RND_FULL  = (SQ_W+1)'(1) << (FRAC_BITS - 1);
   localparam logic [SQ_W:0]   SQ_RND_HALF  = (SQ_W+1)'(1) << FRAC_BITS;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(SAMPLE_MAX);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(SAMPLE_MIN);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   coef_type            ratio_depth_ff, ratio_lateral_ff;
   logic [GRID_W-1:0]   grid_depth_ff, grid_width_ff;
   reg_index_type       csr_index;
   logic                csr_write;

   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_depth_ff   <= '0;
         ratio_lateral_ff <= '0;
         grid_depth_ff    <= GRID_W'(4096);
         grid_width_ff    <= GRID_W'(4096);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_RATIO_DEPTH:   ratio_depth_ff   <= pwdata[COEF_W-1:0];
            REG_RATIO_LATERAL: ratio_lateral_ff <= pwdata[COEF_W-1:0];
            REG_GRID_DEPTH:    grid_depth_ff    <= pwdata[GRID_W-1:0];
            REG_GRID_WIDTH:    grid_width_ff    <= pwdata[GRID_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_RATIO_DEPTH:   prdata = CSR_DATA_W'(ratio_depth_ff);
         REG_RATIO_LATERAL: prdata = CSR_DATA_W'(ratio_lateral_ff);
         REG_GRID_DEPTH:    prdata = CSR_DATA_W'(grid_depth_ff);
         REG_GRID_WIDTH:    prdata = CSR_DATA_W'(grid_width_ff);
      endcase
   end

   // ------------------------------------------------------------------
   // Stage 1: edge classification, differences, Courant products
   // ------------------------------------------------------------------
   logic                    accept;
   logic [NZ_W-1:0]         nz, nx;
   logic signed [CMP_W-1:0] nz_s, nx_s, dep_s, lat_s;
   logic                    mid_lat, mid_dep, at_bottom, at_left, at_right;
   logic signed [DIFF_W-1:0] c_e, up_e, dn_e, lf_e, rt_e, pc_e, pu_e, pl_e, pr_e;
   logic signed [DIFF_W-1:0] u_z, d_z, l_z, r_z;
   logic signed [DIFF_W-1:0] dz_in, dx_in, base_in;
   coef_sel_type            sel_z_in, sel_x_in;
   logic [PROD_W-1:0]       prod_z_in, prod_x_in;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign nz = (NZ_W'(grid_depth_ff) > NZ_W'(MAX_GRID)) ? NZ_W'(MAX_GRID)
                                                         : NZ_W'(grid_depth_ff);
   assign nx = (NZ_W'(grid_width_ff) > NZ_W'(MAX_GRID)) ? NZ_W'(MAX_GRID)
                                                         : NZ_W'(grid_width_ff);
   assign nz_s  = CMP_W'(nz);
   assign nx_s  = CMP_W'(nx);
   assign dep_s = CMP_W'(req_depth_pos);
   assign lat_s = CMP_W'(req_lateral_pos);

   assign mid_lat   = (lat_s >= ONE_S) && (lat_s <= nx_s - TWO_S);
   assign mid_dep   = (dep_s >= ONE_S) && (dep_s <= nz_s - TWO_S);
   assign at_bottom = (dep_s == nz_s - ONE_S) && mid_lat;
   assign at_left   = (lat_s == '0) && mid_dep;
   assign at_right  = (lat_s == nx_s - ONE_S) && mid_dep;

   assign c_e  = DIFF_W'(req_cur_center);
   assign up_e = DIFF_W'(req_cur_up);
   assign dn_e = DIFF_W'(req_cur_down);
   assign lf_e = DIFF_W'(req_cur_left);
   assign rt_e = DIFF_W'(req_cur_right);
   assign pc_e = DIFF_W'(req_prev_center);
   assign pu_e = DIFF_W'(req_prev_up);
   assign pl_e = DIFF_W'(req_prev_left);
   assign pr_e = DIFF_W'(req_prev_right);

   // In the interior rule a neighbor outside the grid counts as zero.
   assign u_z = (dep_s >= ONE_S)        ? up_e : '0;
   assign d_z = (dep_s + ONE_S < nz_s)  ? dn_e : '0;
   assign l_z = (lat_s >= ONE_S)        ? lf_e : '0;
   assign r_z = (lat_s + ONE_S < nx_s)  ? rt_e : '0;

   assign base_in = c_e + c_e - pc_e;

   always_comb begin
      if (at_bottom) begin
         dz_in    = (up_e - c_e) + (pc_e - pu_e);
         dx_in    = lf_e + rt_e - c_e - c_e;
         sel_z_in = COEF_LINEAR;
         sel_x_in = COEF_HALF_SQUARE;
      end else if (at_left) begin
         dz_in    = up_e + dn_e - c_e - c_e;
         dx_in    = (rt_e - c_e) - (pr_e - pc_e);
         sel_z_in = COEF_HALF_SQUARE;
         sel_x_in = COEF_LINEAR;
      end else if (at_right) begin
         dz_in    = up_e + dn_e - c_e - c_e;
         dx_in    = (lf_e - c_e) + (pc_e - pl_e);
         sel_z_in = COEF_HALF_SQUARE;
         sel_x_in = COEF_LINEAR;
      end else begin
         dz_in    = u_z + d_z - c_e - c_e;
         dx_in    = l_z + r_z - c_e - c_e;
         sel_z_in = COEF_SQUARE;
         sel_x_in = COEF_SQUARE;
      end
   end

   assign prod_z_in = PROD_W'(req_velocity) * PROD_W'(ratio_depth_ff);
   assign prod_x_in = PROD_W'(req_velocity) * PROD_W'(ratio_lateral_ff);

   // ------------------------------------------------------------------
   // Pipeline registers
   // ------------------------------------------------------------------
   logic [LAT:1]             valid_ff;
   logic signed [DIFF_W-1:0] dz_ff [1:4];
   logic signed [DIFF_W-1:0] dx_ff [1:4];
   logic signed [DIFF_W-1:0] base_ff [1:7];
   coef_sel_type             sel_z_ff [1:3];
   coef_sel_type             sel_x_ff [1:3];
   logic [PROD_W-1:0]        prod_z_ff, prod_x_ff;
   logic [PROD_W:0]          prod_z_rnd, prod_x_rnd;
   coef_type                 cz_in, cx_in, cz_ff, cx_ff;
   logic [SQ_W-1:0]          sq_z_in, sq_x_in, sq_z_ff, sq_x_ff;
   coef_type                 cz_lin_ff, cx_lin_ff;
   logic [SQ_W:0]            sq_z_full, sq_z_half, sq_x_full, sq_x_half;
   coef_type                 kz_full, kz_half, kx_full, kx_half;
   coef_type                 kz_in, kx_in, kz_ff, kx_ff;
   logic signed [TERM_W-1:0] term_z, term_x;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SAMPLE_BITS-1:0] sample_in, sample_ff;
   logic                     sat_in, sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LAT-1:1], accept};
      end
   end

   // Stage 2: Courant numbers rounded half up to Q2.30 and clipped.
   assign prod_z_rnd = {1'b0, prod_z_ff} + PROD_RND;
   assign prod_x_rnd = {1'b0, prod_x_ff} + PROD_RND;
   assign cz_in = (|prod_z_rnd[PROD_W:COEF_W+2]) ? '1 : prod_z_rnd[COEF_W+1:2];
   assign cx_in = (|prod_x_rnd[PROD_W:COEF_W+2]) ? '1 : prod_x_rnd[COEF_W+1:2];

   // Stage 3: squares.
   assign sq_z_in = SQ_W'(cz_ff) * SQ_W'(cz_ff);
   assign sq_x_in = SQ_W'(cx_ff) * SQ_W'(cx_ff);

   // Stage 4: full and half squares rounded to Q2.30, then the coefficient is chosen.
   assign sq_z_full = {1'b0, sq_z_ff} + SQ_RND_FULL;
   assign sq_z_half = {1'b0, sq_z_ff} + SQ_RND_HALF;
   assign sq_x_full = {1'b0, sq_x_ff} + SQ_RND_FULL;
   assign sq_x_half = {1'b0, sq_x_ff} + SQ_RND_HALF;

   assign kz_full = (|sq_z_full[SQ_W:FRAC_BITS+COEF_W]) ? '1
                    : sq_z_full[FRAC_BITS+COEF_W-1:FRAC_BITS];
   assign kz_half = (|sq_z_half[SQ_W:FRAC_BITS+1+COEF_W]) ? '1
                    : sq_z_half[FRAC_BITS+COEF_W:FRAC_BITS+1];
   assign kx_full = (|sq_x_full[SQ_W:FRAC_BITS+COEF_W]) ? '1
                    : sq_x_full[FRAC_BITS+COEF_W-1:FRAC_BITS];
   assign kx_half = (|sq_x_half[SQ_W:FRAC_BITS+1+COEF_W]) ? '1
                    : sq_x_half[FRAC_BITS+COEF_W:FRAC_BITS+1];

   always_comb begin
      case (sel_z_ff[3])
         COEF_LINEAR:      kz_in = cz_lin_ff;
         COEF_HALF_SQUARE: kz_in = kz_half;
         default:          kz_in = kz_full;
      endcase
      case (sel_x_ff[3])
         COEF_LINEAR:      kx_in = cx_lin_ff;
         COEF_HALF_SQUARE: kx_in = kx_half;
         default:          kx_in = kx_full;
      endcase
   end

   always_ff @(posedge clock) begin
      dz_ff[1]    <= dz_in;
      dx_ff[1]    <= dx_in;
      base_ff[1]  <= base_in;
      sel_z_ff[1] <= sel_z_in;
      sel_x_ff[1] <= sel_x_in;
      prod_z_ff   <= prod_z_in;
      prod_x_ff   <= prod_x_in;
      for (int i = 2; i <= 4; i++) begin
         dz_ff[i] <= dz_ff[i-1];
         dx_ff[i] <= dx_ff[i-1];
      end
      for (int i = 2; i <= 7; i++) begin
         base_ff[i] <= base_ff[i-1];
      end
      for (int i = 2; i <= 3; i++) begin
         sel_z_ff[i] <= sel_z_ff[i-1];
         sel_x_ff[i] <= sel_x_ff[i-1];
      end
      cz_ff     <= cz_in;
      cx_ff     <= cx_in;
      sq_z_ff   <= sq_z_in;
      sq_x_ff   <= sq_x_in;
      cz_lin_ff <= cz_ff;
      cx_lin_ff <= cx_ff;
      kz_ff     <= kz_in;
      kx_ff     <= kx_in;
      sample_ff <= sample_in;
      sat_ff    <= sat_in;
   end

   // Stages 5 to 7: scaling of the two difference terms.
   aws_scale #(
      .DIFF_W (DIFF_W),
      .TERM_W (TERM_W)
   ) u_scale_z (
      .clock (clock),
      .diff  (dz_ff[4]),
      .coef  (kz_ff),
      .term  (term_z)
   );

   aws_scale #(
      .DIFF_W (DIFF_W),
      .TERM_W (TERM_W)
   ) u_scale_x (
      .clock (clock),
      .diff  (dx_ff[4]),
      .coef  (kx_ff),
      .term  (term_x)
   );

   // Stage 8: exact sum and saturation into the output register.
   assign sum_in = SUM_W'(base_ff[7]) + SUM_W'(term_z) + SUM_W'(term_x);

   always_comb begin
      if (sum_in > SAT_HI) begin
         sample_in = SAMPLE_MAX;
         sat_in    = 1'b1;
      end else if (sum_in < SAT_LO) begin
         sample_in = SAMPLE_MIN;
         sat_in    = 1'b1;
      end else begin
         sample_in = sum_in[SAMPLE_BITS-1:0];
         sat_in    = 1'b0;
      end
   end

   assign rsp_valid       = valid_ff[LAT];
   assign rsp_next_sample = sample_ff;
   assign rsp_saturated   = sat_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("result strobe without a transaction accepted %0d cycles earlier", LAT);

   a_saturation_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_next_sample == SAMPLE_MAX || rsp_next_sample == SAMPLE_MIN))
      else $error("saturated result is not at a range limit");

   a_linear_coef_passthrough: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[3] && sel_z_ff[3] == COEF_LINEAR) |=> (kz_ff == $past(cz_ff, 2)))
      else $error("depth edge coefficient differs from the Courant number");

endmodule
